// ===== rtl/core/strm_pkg.sv =====
// ----------------------------------------------------------------------------
// strm_pkg
// Shared constants and types of the sparse table range-max unit.
// ----------------------------------------------------------------------------
package strm_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int LEVELS       = 11;
	localparam int VALUE_WIDTH  = 32;

	localparam int IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int LVL_W  = $clog2(LEVELS);
	localparam int ADDR_W = LVL_W + IDX_W;
	localparam int DEPTH  = LEVELS * MAX_ELEMENTS;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPEND,
		ST_QRD,
		ST_QOUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic app_step;
		logic q_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic app_more;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/strm_ctrl.sv =====
// ----------------------------------------------------------------------------
// strm_ctrl
// Controller: sequences clear, level-by-level append and two-port query.
// ----------------------------------------------------------------------------
module strm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  strm_pkg::sts_t sts,
	output strm_pkg::cmd_t cmd
);
	import strm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				cmd.load = accept;
				if (accept) begin
					case (opcode_t'(opcode))
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						OP_APPEND: begin
							if (!sts.full) begin
								state_d = ST_APPEND;
							end
						end
						OP_QUERY: begin
							state_d = ST_QRD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_APPEND: begin
				cmd.app_step = 1'b1;
				if (!sts.app_more) begin
					state_d = ST_IDLE;
				end
			end
			ST_QRD: begin
				cmd.q_issue = 1'b1;
				state_d     = ST_QOUT;
			end
			ST_QOUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_qrd_to_qout: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QRD |=> state_q == ST_QOUT)
		else $error("query read not followed by result stage");
`endif

endmodule

// ===== rtl/core/strm_dp.sv =====
// ----------------------------------------------------------------------------
// strm_dp
// Datapath: level table memory, element count, append and query arithmetic,
// output register.
// ----------------------------------------------------------------------------
module strm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  strm_pkg::cmd_t                        cmd,
	output strm_pkg::sts_t                        sts,
	input  logic signed [strm_pkg::VALUE_WIDTH-1:0] value,
	input  logic [strm_pkg::IDX_W-1:0]            range_start,
	input  logic [strm_pkg::IDX_W-1:0]            range_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [strm_pkg::VALUE_WIDTH-1:0] max_value,
	output logic                                  range_error
);
	import strm_pkg::*;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];

	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic [LVL_W-1:0]       lv_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] prev_q;
	logic [IDX_W-1:0]       start_q;
	logic [IDX_W-1:0]       end_q;
	logic                   err_q;
	logic [VALUE_WIDTH-1:0] rd_a_q;
	logic [VALUE_WIDTH-1:0] rd_b_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] max_value_q;
	logic                   range_error_q;

	logic [CNT_W:0]         idx_p1;
	logic [CNT_W:0]         span_cur;
	logic [CNT_W:0]         span_nxt;
	logic [LVL_W:0]         lv_p1;
	logic                   app_more;
	logic [IDX_W-1:0]       wr_idx;
	logic [IDX_W-1:0]       rd_idx;
	logic [VALUE_WIDTH-1:0] ap_max;
	logic [VALUE_WIDTH-1:0] wr_data;

	logic                   q_err;
	logic [CNT_W-1:0]       q_len;
	logic [LVL_W-1:0]       q_lg;
	logic [CNT_W:0]         q_span;
	logic [IDX_W-1:0]       q_b;
	logic [VALUE_WIDTH-1:0] q_max;

	logic                   en_a;
	logic                   en_b;
	logic                   wr_en;
	logic [ADDR_W-1:0]      addr_a;
	logic [ADDR_W-1:0]      addr_b;
	logic [ADDR_W-1:0]      addr_w;

	// append: level lv entry ending at idx starts at idx+1-2^lv
	assign idx_p1   = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
	assign lv_p1    = (LVL_W+1)'(lv_q) + (LVL_W+1)'(1);
	assign span_cur = (CNT_W+1)'(1) << lv_q;
	assign span_nxt = (CNT_W+1)'(1) << lv_p1;
	assign app_more = (lv_p1 < (LVL_W+1)'(LEVELS)) && (idx_p1 >= span_nxt);
	assign wr_idx   = IDX_W'(idx_p1 - span_cur);
	assign rd_idx   = IDX_W'(idx_p1 - span_nxt);
	assign ap_max   = ($signed(rd_a_q) >= $signed(prev_q)) ? rd_a_q : prev_q;
	assign wr_data  = (lv_q == '0) ? value_q : ap_max;

	// query
	assign q_err = (start_q > end_q) || ((CNT_W)'(end_q) >= count_q);
	assign q_len = (CNT_W)'(end_q) - (CNT_W)'(start_q) + (CNT_W)'(1);

	always_comb begin
		q_lg = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (q_len[i]) begin
				q_lg = LVL_W'(i);
			end
		end
	end

	assign q_span = (CNT_W+1)'(1) << q_lg;
	assign q_b    = IDX_W'((CNT_W+1)'(end_q) + (CNT_W+1)'(1) - q_span);
	assign q_max  = ($signed(rd_a_q) >= $signed(rd_b_q)) ? rd_a_q : rd_b_q;

	// memory ports
	assign en_a   = cmd.q_issue || (cmd.app_step && app_more);
	assign en_b   = cmd.q_issue;
	assign wr_en  = cmd.app_step;
	assign addr_a = cmd.q_issue ? {q_lg, start_q} : {lv_q, rd_idx};
	assign addr_b = {q_lg, q_b};
	assign addr_w = {lv_q, wr_idx};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_w] <= wr_data;
		end
		if (en_a) begin
			rd_a_q <= mem[addr_a];
		end
		if (en_b) begin
			rd_b_q <= mem[addr_b];
		end
	end

	// transfer payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			start_q <= range_start;
			end_q   <= range_end;
			idx_q   <= IDX_W'(count_q);
			lv_q    <= '0;
		end else if (cmd.app_step) begin
			lv_q <= LVL_W'(lv_p1);
		end
		if (cmd.app_step) begin
			prev_q <= wr_data;
		end
		if (cmd.q_issue) begin
			err_q <= q_err;
		end
		if (cmd.out_load) begin
			max_value_q   <= err_q ? '0 : q_max;
			range_error_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.app_step && !app_more) begin
				count_q <= CNT_W'(idx_p1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.full     = (count_q == CNT_W'(MAX_ELEMENTS));
	assign sts.app_more = app_more;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign max_value   = max_value_q;
	assign range_error = range_error_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && range_error_q |-> max_value_q == '0)
		else $error("range error with nonzero result");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app_step |-> (LVL_W+1)'(lv_q) < (LVL_W+1)'(LEVELS))
		else $error("append level beyond table");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app_step && !app_more |=> count_q == $past(CNT_W'(idx_p1)))
		else $error("count not advanced after append");
`endif

endmodule

// ===== rtl/core/sparse_table_range_max_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_max_unit
// Range-maximum engine over signed values held in a sparse table.
// ----------------------------------------------------------------------------
// Opcode 0 clears the table. Opcode 1 appends a value and fills every level
// entry that ends at the new index, one level per cycle through the table's
// single write port, and an append to a full table is dropped. Opcode 2
// reads two overlapping power-of-two blocks in the same cycle on the two read
// ports and returns their maximum, or zero with range_error set when start
// exceeds end or end is not below the element count. The result waits in an
// output register, so the next item is taken while it is still unread. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module sparse_table_range_max_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              opcode,
	input  logic signed [strm_pkg::VALUE_WIDTH-1:0] value,
	input  logic [strm_pkg::IDX_W-1:0]              range_start,
	input  logic [strm_pkg::IDX_W-1:0]              range_end,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [strm_pkg::VALUE_WIDTH-1:0] max_value,
	output logic                                    range_error
);
	import strm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	strm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	strm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (value),
		.range_start (range_start),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_value   (max_value),
		.range_error (range_error)
	);

endmodule

// ===== tb/sv/sparse_table_range_max_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sparse_table_range_max_unit_tb
// Self-checking bench for the sparse table range-max unit. A local copy of
// the level table is updated on every accepted transfer and predicts each
// query result. Directed cases cover the value extremes, bad ranges, the
// ignored opcode and a full table; random sequences of clears, appends and
// queries run with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module sparse_table_range_max_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import strm_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 30;
	localparam int RAND_ITEMS  = 120;

	typedef logic signed [VALUE_WIDTH-1:0] sval_t;

	typedef struct {
		sval_t mx;
		logic  err;
	} max_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           opcode;
	sval_t                value;
	logic [IDX_W-1:0]     range_start;
	logic [IDX_W-1:0]     range_end;
	logic                 out_valid;
	logic                 out_ready;
	sval_t                max_value;
	logic                 range_error;

	sval_t       lvl_tbl [LEVELS][MAX_ELEMENTS];
	int unsigned n_elems;
	max_result_t max_expected[$];
	int          err_count;
	int          sent_items;
	int          burst_left;
	bit          hold_req;

	sparse_table_range_max_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.value       (value),
		.range_start (range_start),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_value   (max_value),
		.range_error (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sval_t larger_of(input sval_t a, input sval_t b);
		return (a >= b) ? a : b;
	endfunction

	// Shadow table update; queries push the expected result.
	task automatic table_step(input logic [1:0] op, input sval_t v,
			input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] e);
		int unsigned idx, span, base, len, lg, blk_b;
		int lv;
		max_result_t res;
		case (op)
			OP_CLEAR: n_elems = 0;
			OP_APPEND: begin
				if (n_elems < MAX_ELEMENTS) begin
					idx = n_elems;
					lvl_tbl[0][idx] = v;
					for (lv = 1; lv < LEVELS; lv++) begin
						span = 1 << lv;
						if (idx + 1 >= span) begin
							base = idx + 1 - span;
							lvl_tbl[lv][base] = larger_of(lvl_tbl[lv-1][base],
								lvl_tbl[lv-1][base + span/2]);
						end
					end
					n_elems++;
				end
			end
			OP_QUERY: begin
				if (s > e || e >= n_elems) begin
					res.mx  = '0;
					res.err = 1'b1;
				end else begin
					len = e - s + 1;
					lg  = 0;
					while ((len >> (lg + 1)) != 0)
						lg++;
					blk_b   = e + 1 - (1 << lg);
					res.mx  = larger_of(lvl_tbl[lg][s], lvl_tbl[lg][blk_b]);
					res.err = 1'b0;
				end
				max_expected.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// One transfer on the input side, with bursts and random gaps.
	task automatic send_item(input logic [1:0] op, input sval_t v,
			input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] e);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 5))
				0, 1, 2: gap = 0;
				3, 4:    gap = $urandom_range(1, 6);
				default: gap = $urandom_range(7, 25);
			endcase
			burst_left = $urandom_range(1, 32);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid    <= 1'b1;
		opcode      <= op;
		value       <= v;
		range_start <= s;
		range_end   <= e;
		do @(posedge clk); while (!in_ready);
		table_step(op, v, s, e);
		if (op != OP_RESERVED)
			sent_items++;
	endtask

	task automatic idle_sender();
		@(negedge clk);
		in_valid   <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		idle_sender();
		while (max_expected.size() != 0)
			@(posedge clk);
	endtask

	function automatic sval_t pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2, 3:    return sval_t'($urandom_range(0, 15)) - 8;
			default: return sval_t'($urandom);
		endcase
	endfunction

	task automatic do_clear();
		send_item(OP_CLEAR, sval_t'($urandom), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic do_append(input sval_t v);
		send_item(OP_APPEND, v, IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic do_query(input int s, input int e);
		send_item(OP_QUERY, sval_t'($urandom), IDX_W'(s), IDX_W'(e));
	endtask

	// Valid range within the current table; needs at least one element.
	task automatic query_valid();
		int s, e, k;
		e = $urandom_range(0, n_elems - 1);
		case ($urandom_range(0, 2))
			0: s = $urandom_range(0, e);
			1: begin
				k = $urandom_range(0, LEVELS - 1);
				s = e - (1 << k) + 1;
				if (s < 0)
					s = 0;
			end
			default: s = $urandom_range((e > 8) ? e - 8 : 0, e);
		endcase
		do_query(s, e);
	endtask

	task automatic test_directed();
		do_clear();
		do_query(0, 0);
		do_append(32'sh7fff_ffff);
		do_append(32'sh8000_0000);
		do_append(32'sd0);
		do_append(-32'sd1);
		do_append(32'sd1);
		do_query(0, 0);
		do_query(1, 1);
		do_query(0, 4);
		do_query(1, 4);
		do_query(2, 4);
		do_query(1, 3);
		do_query(4, 4);
		do_query(3, 2);
		do_query(0, 5);
		do_query(1023, 1023);
		do_query(0, 1023);
		send_item(OP_RESERVED, sval_t'($urandom), IDX_W'($urandom), IDX_W'($urandom));
		do_query(0, 4);
		do_clear();
		do_query(0, 0);
		do_append(-32'sd5);
		do_query(0, 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		do_clear();
		for (i = 0; i < 16; i++)
			do_append(pick_value());
		hold_req = 1'b1;
		for (i = 0; i < 24; i++)
			query_valid();
		wait_drained();
	endtask

	task automatic test_full_table();
		int i;
		do_clear();
		for (i = 0; i < MAX_ELEMENTS; i++) begin
			do_append(pick_value());
			if (i % 16 == 15)
				query_valid();
		end
		for (i = 0; i < 3; i++)
			do_append(pick_value());
		do_query(0, 1023);
		do_query(1023, 1023);
		do_query(512, 1023);
		do_query(0, 511);
		for (i = 0; i < 8; i++)
			query_valid();
		do_clear();
		do_query(0, 0);
		wait_drained();
	endtask

	task automatic test_random();
		int target, n, k, i;
		target = sent_items + RAND_ITEMS;
		while (sent_items < target) begin
			if ($urandom_range(0, 3) != 0 || n_elems == MAX_ELEMENTS)
				do_clear();
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 250) : $urandom_range(1, 24);
			for (i = 0; i < n; i++)
				do_append(pick_value());
			k = $urandom_range(4, 30);
			for (i = 0; i < k; i++) begin
				case ($urandom_range(0, 19))
					0, 1:    do_query($urandom_range(0, 1023), $urandom_range(0, 1023));
					2:       do_append(pick_value());
					3:       send_item(OP_RESERVED, sval_t'($urandom),
							IDX_W'($urandom), IDX_W'($urandom));
					default: begin
						if (n_elems == 0)
							do_query($urandom_range(0, 1023), $urandom_range(0, 1023));
						else
							query_valid();
					end
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_CLEAR;
		value       = '0;
		range_start = '0;
		range_end   = '0;
		n_elems     = 0;
		err_count   = 0;
		sent_items  = 0;
		burst_left  = 0;
		hold_req    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_full_table();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (max_expected.size() != 0)
			report_mismatch("results missing", 32'(max_expected.size()), 0);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Output side: stall pattern changes mode every so often; long hold on request.
	initial begin
		int mode, mode_left, cyc;
		out_ready = 1'b0;
		mode      = 0;
		mode_left = 0;
		cyc       = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				cyc++;
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (cyc % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		max_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (max_expected.size() == 0) begin
				report_mismatch("unexpected result", max_value, 0);
			end else begin
				want = max_expected.pop_front();
				if (max_value !== want.mx)
					report_mismatch("max_value", max_value, want.mx);
				if (range_error !== want.err)
					report_mismatch("range_error", 32'(range_error), 32'(want.err));
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
rtl/core/strm_pkg.sv
rtl/core/strm_ctrl.sv
rtl/core/strm_dp.sv
rtl/core/sparse_table_range_max_unit.sv
tb/sv/sparse_table_range_max_unit_tb.sv
